### rtl/jfd_pkg.sv
`default_nettype none
package jfd_pkg;

  localparam int LEN_BYTES_DEF   = 4;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [2:0] KIND_DATA    = 3'd0;
  localparam logic [2:0] KIND_GOOD    = 3'd1;
  localparam logic [2:0] KIND_SUMERR  = 3'd2;
  localparam logic [2:0] KIND_BADTYPE = 3'd3;
  localparam logic [2:0] KIND_QUIT    = 3'd4;

  localparam logic [2:0] TYPE_QUIT = 3'd7;

  // Results caused by one request: an optional payload result, then an
  // optional status (or quit) result.
  typedef struct packed {
    logic       has_data;
    logic [7:0] data;
    logic       sink;
    logic       has_status;
    logic [2:0] status;
  } entry_t;

endpackage
`default_nettype wire

### rtl/jfd_front.sv
`default_nettype none
module jfd_front #(
  parameter int LEN_BYTES = jfd_pkg::LEN_BYTES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic [7:0]     in_rx_byte,
  input  wire logic           q_full,
  output jfd_pkg::entry_t     push_entry,
  output logic                push
);

  localparam int LW = 8 * LEN_BYTES;
  localparam int PW = $clog2(LEN_BYTES + 2);
  localparam logic [PW-1:0] PH_HEADER = '0;
  localparam logic [PW-1:0] PH_LAST   = PW'(LEN_BYTES);
  localparam logic [PW-1:0] PH_PAY    = PW'(LEN_BYTES + 1);

  logic [PW-1:0] phase_r, phase_nxt;
  logic [2:0]    job_kind_r, job_kind_nxt;
  logic [4:0]    expected_sum_r, expected_sum_nxt;
  logic [LW-1:0] bytes_left_r, bytes_left_nxt;
  logic [4:0]    running_sum_r, running_sum_nxt;
  logic          stopped_r, stopped_nxt;

  logic          accept;
  logic [LW-1:0] len_acc;
  logic [4:0]    sum_new;
  jfd_pkg::entry_t entry;

  function automatic logic [2:0] frame_status(input logic [4:0] sum,
                                              input logic [4:0] expected,
                                              input logic [2:0] kind);
    logic [2:0] st;
    if (sum != expected) begin
      st = jfd_pkg::KIND_SUMERR;
    end else if (kind > 3'd1) begin
      st = jfd_pkg::KIND_BADTYPE;
    end else begin
      st = jfd_pkg::KIND_GOOD;
    end
    return st;
  endfunction

  assign accept = in_valid && !q_full;
  assign sum_new = running_sum_r + in_rx_byte[4:0];

  always_comb begin
    len_acc = bytes_left_r;
    for (int k = 0; k < LEN_BYTES; k++) begin
      if (phase_r == PW'(k + 1)) begin
        len_acc[8*k +: 8] = in_rx_byte;
      end
    end
  end

  always_comb begin
    phase_nxt        = phase_r;
    job_kind_nxt     = job_kind_r;
    expected_sum_nxt = expected_sum_r;
    bytes_left_nxt   = bytes_left_r;
    running_sum_nxt  = running_sum_r;
    stopped_nxt      = stopped_r;
    entry            = '0;
    entry.sink       = (job_kind_r == 3'd1);
    if (accept && !stopped_r) begin
      if (phase_r == PH_HEADER) begin
        job_kind_nxt     = in_rx_byte[7:5];
        expected_sum_nxt = in_rx_byte[4:0];
        if (in_rx_byte[7:5] == jfd_pkg::TYPE_QUIT) begin
          stopped_nxt      = 1'b1;
          entry.has_status = 1'b1;
          entry.status     = jfd_pkg::KIND_QUIT;
          entry.sink       = 1'b0;
        end else begin
          bytes_left_nxt  = '0;
          running_sum_nxt = '0;
          phase_nxt       = PW'(1);
        end
      end else if (phase_r != PH_PAY) begin
        bytes_left_nxt = len_acc;
        if (phase_r == PH_LAST) begin
          if (len_acc == '0) begin
            // empty frame: report status right away
            entry.has_status = 1'b1;
            entry.status     = frame_status(running_sum_r, expected_sum_r, job_kind_r);
            phase_nxt        = PH_HEADER;
          end else begin
            phase_nxt = PH_PAY;
          end
        end else begin
          phase_nxt = phase_r + PW'(1);
        end
      end else begin
        running_sum_nxt = sum_new;
        bytes_left_nxt  = bytes_left_r - LW'(1);
        if (job_kind_r <= 3'd1) begin
          entry.has_data = 1'b1;
          entry.data     = in_rx_byte;
        end
        if (bytes_left_r == LW'(1)) begin
          entry.has_status = 1'b1;
          entry.status     = frame_status(sum_new, expected_sum_r, job_kind_r);
          phase_nxt        = PH_HEADER;
        end
      end
    end
  end

  assign push_entry = entry;
  assign push       = entry.has_data || entry.has_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEADER;
      job_kind_r     <= '0;
      expected_sum_r <= '0;
      bytes_left_r   <= '0;
      running_sum_r  <= '0;
      stopped_r      <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      job_kind_r     <= job_kind_nxt;
      expected_sum_r <= expected_sum_nxt;
      bytes_left_r   <= bytes_left_nxt;
      running_sum_r  <= running_sum_nxt;
      stopped_r      <= stopped_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/jfd_queue.sv
`default_nettype none
module jfd_queue #(
  parameter int DEPTH = jfd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  jfd_pkg::entry_t      push_entry,
  output logic                 full,
  input  wire logic            pop,
  output logic                 head_valid,
  output jfd_pkg::entry_t      head_entry
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jfd_pkg::entry_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

### rtl/jfd_back.sv
`default_nettype none
module jfd_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        head_valid,
  input  jfd_pkg::entry_t  head_entry,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic             out_sink,
  output logic [7:0]       out_payload_byte,
  output logic             out_last
);

  logic       out_valid_r;
  logic [2:0] kind_r;
  logic       sink_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       pend_valid_r;
  logic [2:0] pend_status_r;
  logic       pend_sink_r;
  logic       load;

  // output slot is free or being taken this cycle
  assign load = !out_valid_r || !out_stall;
  assign pop  = load && !pend_valid_r && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (load) begin
      if (pend_valid_r) begin
        out_valid_r  <= 1'b1;
        pend_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= head_valid;
        pend_valid_r <= head_valid && head_entry.has_data && head_entry.has_status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_valid_r) begin
        kind_r <= pend_status_r;
        sink_r <= pend_sink_r;
        byte_r <= '0;
        last_r <= 1'b1;
      end else if (head_entry.has_data) begin
        kind_r        <= jfd_pkg::KIND_DATA;
        sink_r        <= head_entry.sink;
        byte_r        <= head_entry.data;
        last_r        <= !head_entry.has_status;
        // hold the status until the output slot next loads
        pend_status_r <= head_entry.status;
        pend_sink_r   <= head_entry.sink;
      end else begin
        kind_r <= head_entry.status;
        sink_r <= head_entry.sink;
        byte_r <= '0;
        last_r <= 1'b1;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_sink         = sink_r;
  assign out_payload_byte = byte_r;
  assign out_last         = last_r;

endmodule
`default_nettype wire

### rtl/job_frame_deframer_unit.sv
// Job frame deframer.
// Input channel: in_valid / in_stall carry one received stream byte
// (in_rx_byte) per request. A frame is a header byte (type in bits 7..5,
// checksum in bits 4..0), LEN_BYTES little-endian length bytes and the payload.
// Result channel: out_valid / out_stall carry kind, sink, payload_byte and
// last. Payload bytes of type 0 and 1 frames are forwarded as they arrive;
// a status (good, checksum error, bad type) closes each frame, a type 7
// header gives one quit result and the block then ignores input until reset.
// Throughput: one input byte per cycle while in_stall is low; a byte that
// causes two results (last payload byte plus status) gives two outputs in
// turn, the output side moving one result per cycle while out_stall is low.
// An accepted byte's results pass through the queue, then the output register.
// A queue of QUEUE_DEPTH entries sits between the parser and the output
// stage; while it is full in_stall is high. A stalled output holds its result.
// Synchronous reset (rst_n low) returns the parser to header-expected,
// empties the queue and clears the stopped state.
`default_nettype none
module job_frame_deframer_unit #(
  parameter int LEN_BYTES   = jfd_pkg::LEN_BYTES_DEF,
  parameter int QUEUE_DEPTH = jfd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_kind,
  output logic            out_sink,
  output logic [7:0]      out_payload_byte,
  output logic            out_last
);

  jfd_pkg::entry_t push_entry;
  jfd_pkg::entry_t head_entry;
  logic            push;
  logic            q_full;
  logic            pop;
  logic            head_valid;

  assign in_stall = q_full;

  jfd_front #(
    .LEN_BYTES(LEN_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .push_entry (push_entry),
    .push       (push)
  );

  jfd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  jfd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head_entry       (head_entry),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_sink         (out_sink),
    .out_payload_byte (out_payload_byte),
    .out_last         (out_last)
  );

endmodule
`default_nettype wire
